FILE: sv/fpa_pkg.sv
package fpa_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_LT = 4'd4, OP_GT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MAX = 4'd10, OP_MIN = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_I2F = 4'd14, OP_F2I = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } op_class_t;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} back_state_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic               divide_by_zero;
  } alu_out_t;

  typedef struct packed {
    op_class_t          cls;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] result;
    logic               compare_true;
  } fpa_cmd_t;

endpackage

FILE: sv/fpa_front.sv
module fpa_front
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  alu_in_t  item,
  output fpa_cmd_t cmd
);

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic               lt;
  logic               eq;

  assign a  = item.operand_a;
  assign b  = item.operand_b;
  assign lt = a < b;
  assign eq = a == b;

  always_comb begin
    cmd.cls          = CLS_SIMPLE;
    cmd.operand_a    = a;
    cmd.operand_b    = b;
    cmd.result       = '0;
    cmd.compare_true = 1'b0;
    unique case (opcode_t'(item.opcode))
      OP_ADD: cmd.result = a + b;
      OP_SUB: cmd.result = a - b;
      OP_MUL: cmd.cls = CLS_MUL;
      OP_DIV: cmd.cls = CLS_DIV;
      OP_LT:  cmd.compare_true = lt;
      OP_GT:  cmd.compare_true = !lt && !eq;
      OP_LE:  cmd.compare_true = lt || eq;
      OP_GE:  cmd.compare_true = !lt;
      OP_EQ:  cmd.compare_true = eq;
      OP_NE:  cmd.compare_true = !eq;
      OP_MAX: cmd.result = (!lt && !eq) ? a : b;
      OP_MIN: cmd.result = lt ? a : b;
      OP_INC: cmd.result = a + 32'sd1;
      OP_DEC: cmd.result = a - 32'sd1;
      OP_I2F: cmd.result = a <<< FRAC_BITS;
      OP_F2I: cmd.result = a >>> FRAC_BITS;
      default: cmd.result = '0;
    endcase
  end

endmodule

FILE: sv/fpa_queue.sv
module fpa_queue
  import fpa_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full  = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

FILE: sv/fpa_back.sv
module fpa_back
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  fpa_cmd_t cmd,
  output logic     in_ready,
  output logic     out_valid,
  output alu_out_t out_item,
  input  logic     out_ready
);

  localparam int DIV_STEPS = 32 + FRAC_BITS;
  localparam int CW = $clog2(DIV_STEPS + 1);

  back_state_t        state;
  back_state_t        state_next;
  logic               stage_valid;
  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  logic               neg;
  logic [63:0]        prod;
  logic [DIV_STEPS-1:0] dividend;
  logic [32:0]        rem;
  logic [DIV_STEPS-1:0] quo;
  logic [CW-1:0]      cnt;
  logic [32:0]        rem_shift;
  logic [32:0]        rem_sub;
  logic [63:0]        prod_signed;
  logic [DIV_STEPS-1:0] quo_signed;
  logic               take;
  logic               done_load;
  logic               free_out;

  assign free_out  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE) && free_out;
  assign rem_shift = {rem[31:0], dividend[DIV_STEPS-1]};
  assign rem_sub   = rem_shift - {1'b0, mag_b};
  assign prod_signed = neg ? (64'd0 - prod) : prod;
  assign quo_signed  = neg ? ('0 - quo) : quo;

  always_comb begin
    state_next = state;
    done_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (take && cmd.cls == CLS_MUL) begin
          state_next = ST_MUL;
        end else if (take && cmd.cls == CLS_DIV && cmd.operand_b != '0) begin
          state_next = ST_DIV;
        end
      end
      ST_MUL: state_next = ST_DONE;
      ST_DIV: begin
        if (cnt == CW'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (free_out) begin
          done_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take && (cmd.cls == CLS_SIMPLE ||
                   (cmd.cls == CLS_DIV && cmd.operand_b == '0))) begin
        out_valid <= 1'b1;
      end else if (done_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mag_a <= cmd.operand_a[31] ? 32'd0 - cmd.operand_a : cmd.operand_a;
      mag_b <= cmd.operand_b[31] ? 32'd0 - cmd.operand_b : cmd.operand_b;
      neg   <= cmd.operand_a[31] ^ cmd.operand_b[31];
      cnt   <= '0;
      rem   <= '0;
    end
    if (state == ST_IDLE && take && cmd.cls != CLS_MUL && !(cmd.cls == CLS_DIV &&
        cmd.operand_b != '0)) begin
      out_item <= '{result: (cmd.cls == CLS_DIV) ? INT_MAX : cmd.result,
                    compare_true: cmd.compare_true,
                    divide_by_zero: cmd.cls == CLS_DIV};
    end
    if (state == ST_IDLE && take) begin
      dividend <= {(cmd.operand_a[31] ? 32'd0 - cmd.operand_a : cmd.operand_a),
                   FRAC_BITS'(0)};
    end
    if (state == ST_MUL) begin
      prod <= mag_a * mag_b;
      stage_valid <= 1'b0;
    end
    if (state == ST_DIV) begin
      dividend <= dividend << 1;
      cnt <= cnt + 1'b1;
      if (!rem_sub[32]) begin
        rem <= rem_sub;
        quo <= {quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[DIV_STEPS-2:0], 1'b0};
      end
    end
    if (done_load) begin
      out_item.compare_true   <= 1'b0;
      out_item.divide_by_zero <= 1'b0;
      out_item.result <= stage_valid ? quo_signed[31:0] :
                         prod_signed[FRAC_BITS+31:FRAC_BITS];
    end
    if (state == ST_IDLE && take) begin
      stage_valid <= cmd.cls == CLS_DIV;
    end
  end

endmodule

FILE: sv/fixed_point_alu.sv
// Simple ops pass the queue and result register, one per cycle while results are popped.
// Multiply holds the back end in states ST_MUL and ST_DONE until its product is poppable.
// Divide by a nonzero divisor iterates one quotient bit per cycle, 32+FRAC_BITS bits.
// Such a divide holds the back end until the quotient loads; a waiting result stalls it.
// A four-entry queue decouples the classifying front end from the back end.
// Synchronous active-high reset empties the queue and the result register.
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  alu_in_t  in_item,
  output logic     empty,
  input  logic     pop,
  output alu_out_t out_item
);

  fpa_cmd_t cmd;
  fpa_cmd_t q_cmd;
  logic     q_empty;
  logic     q_rd;
  logic     out_valid;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .item (in_item),
    .cmd  (cmd)
  );

  fpa_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(fpa_cmd_t))) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (cmd),
    .full  (full),
    .rd    (q_rd),
    .rdata (q_cmd),
    .empty (q_empty)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .cmd       (q_cmd),
    .in_ready  (q_rd),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_ready (pop)
  );

  assign empty = !out_valid;

  a_dz_only_maxint: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.divide_by_zero) |-> out_item.result == INT_MAX)
    else $error("divide by zero item without saturated result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(out_item.divide_by_zero && out_item.compare_true))
    else $error("both flags set on one item");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result present right after reset");

endmodule
